// File: hw/rtl/wwlf_pkg.sv
// Shared types and constants for the word-wrap line-fit block.
// No dependencies; used by the stream interface users and the top level.
package wwlf_pkg;

    // Character codes that steer the scan
    localparam logic [15:0] CH_NEWLINE = 16'h000A;
    localparam logic [15:0] CH_SPACE   = 16'h0020;
    localparam logic [15:0] CH_HYPHEN  = 16'h002D;

    // Stop causes reported with each result
    localparam logic [1:0] STOP_NEWLINE    = 2'd0;
    localparam logic [1:0] STOP_TOO_WIDE   = 2'd1;
    localparam logic [1:0] STOP_CHAR_LIMIT = 2'd2;
    localparam logic [1:0] STOP_END_TEXT   = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_LINE_WIDTH_LIMIT = 2'd0;
    localparam logic [1:0] CFG_WORD_WRAP        = 2'd1;
    localparam logic [1:0] CFG_MAX_CHARS        = 2'd2;

    // One character word
    typedef struct packed {
        logic        first;
        logic        end_of_text;
        logic [15:0] code;
        logic [7:0]  glyph_width;
        logic [1:0]  byte_len;
    } t_char_item;

    // One line result word
    typedef struct packed {
        logic [15:0] char_count;
        logic [11:0] line_width;
        logic [15:0] next_byte_offset;
        logic [1:0]  stop_cause;
    } t_line_result;

    // One configuration write word
    typedef struct packed {
        logic [1:0]  reg_index;
        logic [15:0] data;
    } t_cfg_write;

endpackage

// File: hw/rtl/wwlf_stream_if.sv
// Valid/ready channel carrying one payload word per handshake.
// Payload type is a parameter; no other dependencies.
interface wwlf_stream_if #(parameter type t_payload = logic) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: hw/rtl/word_wrap_line_fit_top.sv
// Word-wrap line fit: greedy line breaker over one character word per cycle while no held result stalls it.
// Registers: an accepted word goes to the input register, its result to the result register.
// Throughput: one character per cycle, set by the scan state update on each processed word;
// a held result that is not taken stalls the input.
// Reset: synchronous active-low i_rst_n clears config, empties both registers and
// leaves the scan finished until a word with first set arrives.
// Depends on wwlf_pkg and wwlf_stream_if.
module word_wrap_line_fit_top
    import wwlf_pkg::*;
#(
    parameter int WIDTH_BITS = 12,
    parameter int COUNT_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    wwlf_stream_if.sink   i_cfg,
    wwlf_stream_if.sink   i_item,
    wwlf_stream_if.source o_result
);

    // Configuration registers
    logic [11:0] r_line_width_limit;
    logic        r_word_wrap;
    logic [15:0] r_max_chars;

    // Input register
    logic       r_in_valid;
    t_char_item r_in;

    // Result register
    logic         r_out_valid;
    t_line_result r_out;

    // Scan state
    logic [WIDTH_BITS-1:0] r_rem, n_rem, c_rem;
    logic [WIDTH_BITS-1:0] r_total, n_total, c_total;
    logic [COUNT_BITS-1:0] r_count, n_count, c_count;
    logic [COUNT_BITS-1:0] r_off, n_off, c_off;
    logic [15:0]           r_last, n_last, c_last;
    logic                  r_brk_valid, n_brk_valid, c_brk_valid;
    logic [COUNT_BITS-1:0] r_brk_count, n_brk_count, c_brk_count;
    logic [COUNT_BITS-1:0] r_brk_off, n_brk_off, c_brk_off;
    logic [WIDTH_BITS-1:0] r_brk_width, n_brk_width, c_brk_width;
    logic                  r_finished, n_finished, c_finished;

    logic                  proc_fire;
    logic                  emit;
    t_line_result          n_out;
    logic                  is_nl;
    logic                  is_space;
    logic                  too_wide;
    logic                  last_space;
    logic [WIDTH_BITS:0]   total_sum;
    logic [COUNT_BITS:0]   off_sum;
    logic [COUNT_BITS:0]   count_sum;
    logic [WIDTH_BITS-1:0] total_sat;
    logic [COUNT_BITS-1:0] off_sat;
    logic [COUNT_BITS-1:0] count_sat;

    // Process the held word once the result register can take a word
    assign proc_fire    = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_in_valid || proc_fire;
    assign i_cfg.ready  = 1'b1;

    assign o_result.valid   = r_out_valid;
    assign o_result.payload = r_out;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width_limit <= '0;
            r_word_wrap        <= 1'b0;
            r_max_chars        <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.payload.reg_index)
                CFG_LINE_WIDTH_LIMIT: r_line_width_limit <= i_cfg.payload.data[11:0];
                CFG_WORD_WRAP:        r_word_wrap        <= i_cfg.payload.data[0];
                CFG_MAX_CHARS:        r_max_chars        <= i_cfg.payload.data;
                default: ;
            endcase
        end
    end

    // Input register: load a new word whenever the slot frees up
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in <= i_item.payload;
        end
    end

    // Start from cleared state when first is set
    always_comb begin
        if (r_in.first) begin
            c_rem       = WIDTH_BITS'(r_line_width_limit);
            c_total     = '0;
            c_count     = '0;
            c_off       = '0;
            c_last      = '0;
            c_brk_valid = 1'b0;
            c_brk_count = '0;
            c_brk_off   = '0;
            c_brk_width = '0;
            c_finished  = 1'b0;
        end else begin
            c_rem       = r_rem;
            c_total     = r_total;
            c_count     = r_count;
            c_off       = r_off;
            c_last      = r_last;
            c_brk_valid = r_brk_valid;
            c_brk_count = r_brk_count;
            c_brk_off   = r_brk_off;
            c_brk_width = r_brk_width;
            c_finished  = r_finished;
        end
    end

    // Character classes and saturating sums
    assign is_nl      = (r_in.code == CH_NEWLINE);
    assign is_space   = (r_in.code == CH_SPACE);
    assign last_space = (c_last == CH_SPACE);
    assign too_wide   = (WIDTH_BITS'(r_in.glyph_width) > c_rem);

    assign total_sum = {1'b0, c_total} + (WIDTH_BITS+1)'(r_in.glyph_width);
    assign off_sum   = {1'b0, c_off} + (COUNT_BITS+1)'(r_in.byte_len);
    assign count_sum = {1'b0, c_count} + (COUNT_BITS+1)'(1);

    assign total_sat = total_sum[WIDTH_BITS] ? '1 : total_sum[WIDTH_BITS-1:0];
    assign off_sat   = off_sum[COUNT_BITS]   ? '1 : off_sum[COUNT_BITS-1:0];
    assign count_sat = count_sum[COUNT_BITS] ? '1 : count_sum[COUNT_BITS-1:0];

    // One scan step
    always_comb begin
        n_rem       = c_rem;
        n_total     = c_total;
        n_count     = c_count;
        n_off       = c_off;
        n_last      = c_last;
        n_brk_valid = c_brk_valid;
        n_brk_count = c_brk_count;
        n_brk_off   = c_brk_off;
        n_brk_width = c_brk_width;
        n_finished  = c_finished;
        emit        = 1'b0;
        n_out       = '0;

        if (!c_finished) begin
            if (r_in.end_of_text) begin
                emit                   = 1'b1;
                n_out.char_count       = 16'(c_count);
                n_out.line_width       = 12'(c_total);
                n_out.next_byte_offset = 16'(c_off);
                n_out.stop_cause       = STOP_END_TEXT;
            end else if (is_nl || too_wide) begin
                emit             = 1'b1;
                n_out.stop_cause = is_nl ? STOP_NEWLINE : STOP_TOO_WIDE;
                // Fall back to the remembered break point
                if (r_word_wrap && !is_space && c_brk_valid && (!is_nl || last_space)) begin
                    n_out.char_count       = 16'(c_brk_count);
                    n_out.line_width       = 12'(c_brk_width);
                    n_out.next_byte_offset = 16'(c_brk_off);
                end else begin
                    n_out.char_count       = 16'(c_count);
                    n_out.line_width       = 12'(c_total);
                    n_out.next_byte_offset = 16'(c_off);
                end
            end else begin
                // Break left of the first space of a run
                if (is_space && !last_space) begin
                    n_brk_valid = 1'b1;
                    n_brk_count = c_count;
                    n_brk_off   = c_off;
                    n_brk_width = c_total;
                end
                n_rem   = c_rem - WIDTH_BITS'(r_in.glyph_width);
                n_total = total_sat;
                n_off   = off_sat;
                n_count = count_sat;
                // Break right of a hyphen not after a space
                if (r_in.code == CH_HYPHEN && !last_space) begin
                    n_brk_valid = 1'b1;
                    n_brk_count = count_sat;
                    n_brk_off   = off_sat;
                    n_brk_width = total_sat;
                end
                n_last = r_in.code;
                if ((r_max_chars != '0) && (32'(count_sat) == 32'(r_max_chars))) begin
                    emit                   = 1'b1;
                    n_out.char_count       = 16'(count_sat);
                    n_out.line_width       = 12'(total_sat);
                    n_out.next_byte_offset = 16'(off_sat);
                    n_out.stop_cause       = STOP_CHAR_LIMIT;
                end
            end
            if (emit) begin
                n_finished = 1'b1;
            end
        end
    end

    // Commit scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem       <= '0;
            r_total     <= '0;
            r_count     <= '0;
            r_off       <= '0;
            r_last      <= '0;
            r_brk_valid <= 1'b0;
            r_brk_count <= '0;
            r_brk_off   <= '0;
            r_brk_width <= '0;
            r_finished  <= 1'b1;
        end else if (proc_fire) begin
            r_rem       <= n_rem;
            r_total     <= n_total;
            r_count     <= n_count;
            r_off       <= n_off;
            r_last      <= n_last;
            r_brk_valid <= n_brk_valid;
            r_brk_count <= n_brk_count;
            r_brk_off   <= n_brk_off;
            r_brk_width <= n_brk_width;
            r_finished  <= n_finished;
        end
    end

    // Result register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_fire && emit) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_fire && emit) begin
            r_out <= n_out;
        end
    end

endmodule
